### hdl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg: chunked body decoder shared types
// Parser phases, result status codes, request and result payload structs,
// and the character helpers used by the step logic.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE      = 3'd0,
    PH_DATA      = 3'd1,
    PH_DATA_END  = 3'd2,
    PH_FINAL_END = 3'd3,
    PH_DONE      = 3'd4,
    PH_BAD       = 3'd5,
    PH_LARGE     = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_CONSUMED = 3'd0,
    ST_DATA     = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_BAD      = 3'd3,
    ST_LARGE    = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] out_byte;
  } out_item_t;

  localparam logic [7:0]  CHR_CR   = 8'h0D;
  localparam logic [7:0]  CHR_LF   = 8'h0A;
  localparam logic [7:0]  CHR_SEMI = 8'h3B;
  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### hdl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// A request is held in the input register, then its result is registered in
// the result register and shown at out_valid.
// Throughput: one byte per cycle when out_stall is low; the per-byte parser
// step is a single combinational pass between the two registers.
// Reset (rst_n low, synchronous): both stages empty, parser in the size line
// phase with all counters zero, body size limit back to 1 MiB.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: chunked transfer-coding body decoder
// Parses chunk-size lines, passes chunk data bytes out and reports
// completion, bad request or payload too large, one result per input byte.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
  parameter int COUNT_BITS    = 32,
  parameter int SIZE_ACC_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hcbd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hcbd_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data
);

  logic                     in_valid_r;
  hcbd_pkg::in_item_t       in_q_r;
  logic                     out_valid_r;
  hcbd_pkg::out_item_t      out_q_r;
  logic [31:0]              max_body_r;

  hcbd_pkg::phase_t         phase_r,        phase_nxt;
  logic                     cr_pending_r,   cr_pending_nxt;
  logic [SIZE_ACC_BITS-1:0] size_value_r,   size_value_nxt;
  logic                     digit_seen_r,   digit_seen_nxt;
  logic                     in_extension_r, in_extension_nxt;
  logic                     line_bad_r,     line_bad_nxt;
  logic [COUNT_BITS-1:0]    bytes_left_r,   bytes_left_nxt;
  logic [COUNT_BITS-1:0]    body_count_r,   body_count_nxt;
  hcbd_pkg::out_item_t      result;

  logic advance;
  logic in_take;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  hcbd_step #(
    .COUNT_BITS    (COUNT_BITS),
    .SIZE_ACC_BITS (SIZE_ACC_BITS)
  ) u_step (
    .item             (in_q_r),
    .body_limit       (max_body_r),
    .phase            (phase_r),
    .cr_pending       (cr_pending_r),
    .size_value       (size_value_r),
    .digit_seen       (digit_seen_r),
    .in_extension     (in_extension_r),
    .line_bad         (line_bad_r),
    .bytes_left       (bytes_left_r),
    .body_count       (body_count_r),
    .phase_nxt        (phase_nxt),
    .cr_pending_nxt   (cr_pending_nxt),
    .size_value_nxt   (size_value_nxt),
    .digit_seen_nxt   (digit_seen_nxt),
    .in_extension_nxt (in_extension_nxt),
    .line_bad_nxt     (line_bad_nxt),
    .bytes_left_nxt   (bytes_left_nxt),
    .body_count_nxt   (body_count_nxt),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      max_body_r     <= hcbd_pkg::MAX_BODY_RESET;
      phase_r        <= hcbd_pkg::PH_SIZE;
      cr_pending_r   <= 1'b0;
      size_value_r   <= '0;
      digit_seen_r   <= 1'b0;
      in_extension_r <= 1'b0;
      line_bad_r     <= 1'b0;
      bytes_left_r   <= '0;
      body_count_r   <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        phase_r        <= phase_nxt;
        cr_pending_r   <= cr_pending_nxt;
        size_value_r   <= size_value_nxt;
        digit_seen_r   <= digit_seen_nxt;
        in_extension_r <= in_extension_nxt;
        line_bad_r     <= line_bad_nxt;
        bytes_left_r   <= bytes_left_nxt;
        body_count_r   <= body_count_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        max_body_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_r <= in_data;
    end
    if (advance) begin
      out_q_r <= result;
    end
  end

  // Input stage only backs up when the result register is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

  // Errors are sticky until a restart request.
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_q_r.restart && phase_r == hcbd_pkg::PH_BAD)
      |=> (phase_r == hcbd_pkg::PH_BAD && out_q_r.status == hcbd_pkg::ST_BAD))
    else $error("bad request state left without restart");

  // A byte taken in the data phase comes out as a data result.
  a_data_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_q_r.restart && phase_r == hcbd_pkg::PH_DATA)
      |=> (out_valid_r && out_q_r.status == hcbd_pkg::ST_DATA
           && out_q_r.out_byte == $past(in_q_r.in_byte)))
    else $error("chunk data byte not passed out");

  // Only data results carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_q_r.status != hcbd_pkg::ST_DATA) |-> (out_q_r.out_byte == 8'd0))
    else $error("non-data result carries a byte");

endmodule

### hdl/hcbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step: per-byte parser step
// Combinational next-state and result for one body byte, given the current
// parser state and the body size limit.
// ----------------------------------------------------------------------------
module hcbd_step #(
  parameter int COUNT_BITS    = 32,
  parameter int SIZE_ACC_BITS = 64
) (
  input  hcbd_pkg::in_item_t      item,
  input  logic [31:0]             body_limit,
  input  hcbd_pkg::phase_t        phase,
  input  logic                    cr_pending,
  input  logic [SIZE_ACC_BITS-1:0] size_value,
  input  logic                    digit_seen,
  input  logic                    in_extension,
  input  logic                    line_bad,
  input  logic [COUNT_BITS-1:0]   bytes_left,
  input  logic [COUNT_BITS-1:0]   body_count,
  output hcbd_pkg::phase_t        phase_nxt,
  output logic                    cr_pending_nxt,
  output logic [SIZE_ACC_BITS-1:0] size_value_nxt,
  output logic                    digit_seen_nxt,
  output logic                    in_extension_nxt,
  output logic                    line_bad_nxt,
  output logic [COUNT_BITS-1:0]   bytes_left_nxt,
  output logic [COUNT_BITS-1:0]   body_count_nxt,
  output hcbd_pkg::out_item_t     result
);

  localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - COUNT_BITS);
  localparam logic [COUNT_BITS-1:0] CNT_ONES = {COUNT_BITS{1'b1}};

  hcbd_pkg::phase_t        ph;
  logic                    crp;
  logic [SIZE_ACC_BITS-1:0] sz;
  logic                    dseen;
  logic                    ext;
  logic                    lbad;
  logic [COUNT_BITS-1:0]   left;
  logic [COUNT_BITS-1:0]   bcnt;
  logic [7:0]              c;
  logic [4:0]              hx;
  logic [63:0]             mx64;
  logic [63:0]             bc64;
  logic [63:0]             limit;
  logic                    too_large;
  logic                    size_zero;
  logic                    ovf;
  logic [COUNT_BITS-1:0]   left_dec;

  // Restart drops all parser state before the byte is looked at.
  always_comb begin
    if (item.restart) begin
      ph    = hcbd_pkg::PH_SIZE;
      crp   = 1'b0;
      sz    = '0;
      dseen = 1'b0;
      ext   = 1'b0;
      lbad  = 1'b0;
      left  = '0;
      bcnt  = '0;
    end else begin
      ph    = phase;
      crp   = cr_pending;
      sz    = size_value;
      dseen = digit_seen;
      ext   = in_extension;
      lbad  = line_bad;
      left  = bytes_left;
      bcnt  = body_count;
    end
  end

  assign c    = item.in_byte;
  assign hx   = hcbd_pkg::hex_digit(c);
  assign mx64 = 64'(body_limit);
  assign bc64 = 64'(bcnt);

  always_comb begin
    limit = (bc64 >= mx64) ? 64'd0 : (mx64 - bc64);
    if (limit > CNT_MAX) begin
      limit = CNT_MAX;
    end
  end

  assign too_large = 64'(sz) > limit;
  assign size_zero = (sz == '0);
  // Shifting in one more digit overflows when the top nibble is in use.
  assign ovf       = (sz[SIZE_ACC_BITS-1 -: 4] != 4'd0);
  assign left_dec  = (left != '0) ? (left - 1'b1) : left;

  always_comb begin
    phase_nxt        = ph;
    cr_pending_nxt   = crp;
    size_value_nxt   = sz;
    digit_seen_nxt   = dseen;
    in_extension_nxt = ext;
    line_bad_nxt     = lbad;
    bytes_left_nxt   = left;
    body_count_nxt   = bcnt;
    result.status    = hcbd_pkg::ST_CONSUMED;
    result.out_byte  = 8'd0;

    case (ph)
      hcbd_pkg::PH_SIZE: begin
        if ((crp && c == hcbd_pkg::CHR_LF) || (!crp && c == hcbd_pkg::CHR_LF)) begin
          // end of size line: validate and load the chunk
          cr_pending_nxt   = 1'b0;
          size_value_nxt   = '0;
          digit_seen_nxt   = 1'b0;
          in_extension_nxt = 1'b0;
          line_bad_nxt     = 1'b0;
          if (lbad || !dseen) begin
            phase_nxt     = hcbd_pkg::PH_BAD;
            result.status = hcbd_pkg::ST_BAD;
          end else if (too_large) begin
            phase_nxt     = hcbd_pkg::PH_LARGE;
            result.status = hcbd_pkg::ST_LARGE;
          end else begin
            bytes_left_nxt = COUNT_BITS'(sz);
            phase_nxt      = size_zero ? hcbd_pkg::PH_FINAL_END : hcbd_pkg::PH_DATA;
          end
        end else if (crp) begin
          cr_pending_nxt = 1'b0;
          phase_nxt      = hcbd_pkg::PH_BAD;
          result.status  = hcbd_pkg::ST_BAD;
        end else if (c == hcbd_pkg::CHR_CR) begin
          cr_pending_nxt = 1'b1;
        end else if (ext) begin
          // skip extension text
        end else if (c == hcbd_pkg::CHR_SEMI) begin
          in_extension_nxt = 1'b1;
        end else if (lbad) begin
          // hold the first error until line end
        end else if (!hx[4] || ovf) begin
          line_bad_nxt = 1'b1;
        end else begin
          size_value_nxt = {sz[SIZE_ACC_BITS-5:0], hx[3:0]};
          digit_seen_nxt = 1'b1;
        end
      end
      hcbd_pkg::PH_DATA: begin
        result.status   = hcbd_pkg::ST_DATA;
        result.out_byte = c;
        body_count_nxt  = (bcnt != CNT_ONES) ? (bcnt + 1'b1) : bcnt;
        bytes_left_nxt  = left_dec;
        if (left_dec == '0) begin
          phase_nxt = hcbd_pkg::PH_DATA_END;
        end
      end
      hcbd_pkg::PH_DATA_END, hcbd_pkg::PH_FINAL_END: begin
        if (crp ? (c != hcbd_pkg::CHR_LF)
                : (c != hcbd_pkg::CHR_CR && c != hcbd_pkg::CHR_LF)) begin
          cr_pending_nxt = 1'b0;
          phase_nxt      = hcbd_pkg::PH_BAD;
          result.status  = hcbd_pkg::ST_BAD;
        end else if (c == hcbd_pkg::CHR_CR) begin
          cr_pending_nxt = 1'b1;
        end else begin
          cr_pending_nxt = 1'b0;
          if (ph == hcbd_pkg::PH_FINAL_END) begin
            phase_nxt     = hcbd_pkg::PH_DONE;
            result.status = hcbd_pkg::ST_COMPLETE;
          end else begin
            phase_nxt = hcbd_pkg::PH_SIZE;
          end
        end
      end
      hcbd_pkg::PH_DONE: begin
        result.status = hcbd_pkg::ST_IGNORED;
      end
      hcbd_pkg::PH_BAD: begin
        result.status = hcbd_pkg::ST_BAD;
      end
      hcbd_pkg::PH_LARGE: begin
        result.status = hcbd_pkg::ST_LARGE;
      end
      default: begin
        cr_pending_nxt = 1'b0;
        phase_nxt      = hcbd_pkg::PH_BAD;
        result.status  = hcbd_pkg::ST_BAD;
      end
    endcase
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: chunked body decoder check
// Drives raw chunked-body bytes through the decoder under random sender gaps
// and receiver stalls. A local model of the chunk parser predicts one status
// and byte per request; each result is compared against the oldest
// prediction. Covers size lines, extensions, delimiters, limits and errors.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          TIMEOUT_CYCLES = 200000;
  localparam int          MAX_REPORTS    = 40;
  localparam logic [63:0] ACC_MAX        = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hcbd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hcbd_pkg::out_item_t out_data;
  logic                cfg_wr_en;
  logic [31:0]         cfg_wr_data;

  // Parser model state
  hcbd_pkg::phase_t    ph;
  logic                cr_pend;
  logic [63:0]         size_acc;
  logic                have_digit;
  logic                in_ext;
  logic                bad_line;
  logic [31:0]         left_cnt;
  logic [31:0]         body_total;
  logic [31:0]         max_body;

  hcbd_pkg::out_item_t pending_decodes[$];
  hcbd_pkg::out_item_t oldest_result;
  logic [7:0]          stream_q[$];
  int                  mismatch_count = 0;
  int                  bytes_sent = 0;
  int                  burst_left = 0;
  int                  cycle_count = 0;
  int                  stall_mode = 0;

  http_chunked_body_decoder #(
    .COUNT_BITS    (32),
    .SIZE_ACC_BITS (64)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Watchdog and receiver stall pattern
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
    if (cycle_count % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (cycle_count % 8 < 3);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------- model
  function automatic void clear_parser();
    ph         = hcbd_pkg::PH_SIZE;
    cr_pend    = 1'b0;
    size_acc   = '0;
    have_digit = 1'b0;
    in_ext     = 1'b0;
    bad_line   = 1'b0;
    left_cnt   = '0;
    body_total = '0;
  endfunction

  function automatic hcbd_pkg::status_t enter_error(input hcbd_pkg::phase_t p);
    ph      = p;
    cr_pend = 1'b0;
    return (p == hcbd_pkg::PH_BAD) ? hcbd_pkg::ST_BAD : hcbd_pkg::ST_LARGE;
  endfunction

  function automatic hcbd_pkg::status_t close_size_line();
    logic [63:0] sz;
    logic [31:0] room;
    logic        bad;
    sz         = size_acc;
    bad        = bad_line || !have_digit;
    cr_pend    = 1'b0;
    size_acc   = '0;
    have_digit = 1'b0;
    in_ext     = 1'b0;
    bad_line   = 1'b0;
    if (bad) return enter_error(hcbd_pkg::PH_BAD);
    room = (body_total >= max_body) ? 32'd0 : max_body - body_total;
    if (sz > {32'd0, room}) return enter_error(hcbd_pkg::PH_LARGE);
    left_cnt = sz[31:0];
    ph = (sz == 0) ? hcbd_pkg::PH_FINAL_END : hcbd_pkg::PH_DATA;
    return hcbd_pkg::ST_CONSUMED;
  endfunction

  function automatic hcbd_pkg::out_item_t decode_byte(input hcbd_pkg::in_item_t item);
    hcbd_pkg::out_item_t r;
    logic [7:0]          c;
    logic [3:0]          dv;
    logic                is_hex;
    r.status   = hcbd_pkg::ST_CONSUMED;
    r.out_byte = 8'd0;
    c = item.in_byte;
    if (item.restart) clear_parser();
    case (ph)
      hcbd_pkg::PH_SIZE: begin
        if (cr_pend) begin
          if (c != hcbd_pkg::CHR_LF) r.status = enter_error(hcbd_pkg::PH_BAD);
          else r.status = close_size_line();
        end else if (c == hcbd_pkg::CHR_CR) begin
          cr_pend = 1'b1;
        end else if (c == hcbd_pkg::CHR_LF) begin
          r.status = close_size_line();
        end else if (!in_ext) begin
          if (c == hcbd_pkg::CHR_SEMI) begin
            in_ext = 1'b1;
          end else if (!bad_line) begin
            is_hex = 1'b1;
            dv     = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) dv = 4'(c - 8'h30);       // 0-9
            else if (c >= 8'h61 && c <= 8'h66) dv = 4'(c - 8'h57);  // a-f
            else if (c >= 8'h41 && c <= 8'h46) dv = 4'(c - 8'h37);  // A-F
            else is_hex = 1'b0;
            if (!is_hex) bad_line = 1'b1;
            else if (size_acc > ((ACC_MAX - {60'd0, dv}) >> 4)) bad_line = 1'b1;
            else begin
              size_acc   = {size_acc[59:0], dv};
              have_digit = 1'b1;
            end
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        r.status   = hcbd_pkg::ST_DATA;
        r.out_byte = c;
        if (body_total != COUNT_MAX) body_total++;
        if (left_cnt != 0) left_cnt--;
        if (left_cnt == 0) ph = hcbd_pkg::PH_DATA_END;
      end
      hcbd_pkg::PH_DATA_END, hcbd_pkg::PH_FINAL_END: begin
        if (cr_pend ? (c != hcbd_pkg::CHR_LF)
                    : (c != hcbd_pkg::CHR_CR && c != hcbd_pkg::CHR_LF)) begin
          r.status = enter_error(hcbd_pkg::PH_BAD);
        end else if (c == hcbd_pkg::CHR_CR) begin
          cr_pend = 1'b1;
        end else begin
          cr_pend = 1'b0;
          if (ph == hcbd_pkg::PH_FINAL_END) begin
            ph       = hcbd_pkg::PH_DONE;
            r.status = hcbd_pkg::ST_COMPLETE;
          end else begin
            ph = hcbd_pkg::PH_SIZE;
          end
        end
      end
      hcbd_pkg::PH_DONE:  r.status = hcbd_pkg::ST_IGNORED;
      hcbd_pkg::PH_BAD:   r.status = hcbd_pkg::ST_BAD;
      hcbd_pkg::PH_LARGE: r.status = hcbd_pkg::ST_LARGE;
      default:            r.status = enter_error(hcbd_pkg::PH_BAD);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Outputs settle long before the falling edge; a result seen here with
  // stall low is taken at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("result with no request pending", int'(out_data.status), 0);
      end else begin
        oldest_result = pending_decodes.pop_front();
        if (out_data.status !== oldest_result.status)
          report_mismatch("status", int'(out_data.status), int'(oldest_result.status));
        if (out_data.out_byte !== oldest_result.out_byte)
          report_mismatch("out_byte", int'(out_data.out_byte),
                          int'(oldest_result.out_byte));
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_byte(input logic [7:0] b, input logic rs);
    hcbd_pkg::in_item_t item;
    bit                 granted;
    item.in_byte = b;
    item.restart = rs;
    in_valid <= 1'b1;
    in_data  <= item;
    granted = 0;
    while (!granted) begin
      @(negedge clk);
      granted = !in_stall;
      @(posedge clk);
    end
    pending_decodes.insert(pending_decodes.size(), decode_byte(item));
    bytes_sent++;
    // Hold valid within a burst, drop it for a random gap between bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
    end
  endtask

  task automatic send_text(input string s, input logic rs);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], rs && (i == 0));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_body(input logic [31:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_body  = v;
  endtask

  // ---------------------------------------------------------------- stream build
  function automatic void put_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + {4'd0, n};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  function automatic void put_eol();
    if ($urandom_range(0, 1)) put_byte(hcbd_pkg::CHR_CR);
    put_byte(hcbd_pkg::CHR_LF);
  endfunction

  function automatic void put_size_line(input logic [63:0] sz);
    int         nd;
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) put_byte(8'h30);
    nd = 1;
    for (int i = 1; i < 16; i++) if (sz[i*4 +: 4] != 0) nd = i + 1;
    for (int i = nd - 1; i >= 0; i--) put_byte(hex_char(sz[i*4 +: 4]));
    if ($urandom_range(0, 3) == 0) begin
      put_byte(hcbd_pkg::CHR_SEMI);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (b == hcbd_pkg::CHR_CR || b == hcbd_pkg::CHR_LF) b = 8'h3D;
        put_byte(b);
      end
    end
    put_eol();
  endfunction

  task automatic send_random_body();
    int          kind;
    int          len;
    int          pos;
    bit          cut;
    logic        rs;
    logic [63:0] sz;
    stream_q.delete();
    cut = 0;
    for (int k = $urandom_range(0, 4); k > 0 && !cut; k--) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // more digits than the accumulator holds
        put_byte(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(16, 19)) put_byte(hex_char(4'($urandom_range(0, 15))));
        put_eol();
        cut = 1;
      end else if (kind == 1) begin
        // huge declared size, body cut short by the next restart
        sz = {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
        put_size_line(sz);
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
        cut = 1;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        put_size_line(64'(len));
        repeat (len) put_byte(8'($urandom_range(0, 255)));
        put_eol();
      end
    end
    if (!cut) begin
      put_size_line(64'd0);
      put_eol();
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
    end
    // corrupt about one body in four
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, stream_q.size() - 1);
      case ($urandom_range(0, 2))
        0: stream_q[pos] = 8'($urandom_range(0, 255));
        1: stream_q.insert(pos, 8'($urandom_range(0, 255)));
        default: stream_q[pos] = hcbd_pkg::CHR_CR;
      endcase
    end
    rs = ($urandom_range(0, 9) != 0);
    foreach (stream_q[i]) send_byte(stream_q[i], rs && (i == 0));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_chunk_basics();
    // extension, bare LF, a 0xFF data byte, completion, then an ignored byte
    send_text("1;x\n", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("\n0\r\n\r\n", 1'b0);
    send_byte(8'h00, 1'b0);
    // empty size line, error stays sticky
    send_text("\r\nZ", 1'b1);
    // stray carriage return on the size line
    send_text("1\rX", 1'b1);
    // missing chunk delimiter
    send_text("1\nAB", 1'b1);
    // size above the default limit, sticky
    send_text("100001\n0", 1'b1);
  endtask

  task automatic test_size_limits();
    set_max_body(32'd0);
    send_text("0\n\n", 1'b1);
    send_text("1\n", 1'b1);
    set_max_body(32'hFFFF_FFFF);
    send_text("FFFFFFFF\n", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("100000000\n", 1'b1);
    send_text("10000000000000000\n", 1'b1);
    send_text("fg\n", 1'b1);
    set_max_body(32'd6);
    send_text("3\nabc\n4\n", 1'b1);
    send_text("6;ext\r\nabcdef\r\n0\r\n\r\n", 1'b1);
  endtask

  task automatic test_random_streams();
    logic [31:0] limit_list[0:5];
    int          target;
    limit_list[0] = hcbd_pkg::MAX_BODY_RESET;
    limit_list[1] = $urandom_range(8, 64);
    limit_list[2] = 32'd0;
    limit_list[3] = 32'hFFFF_FFFF;
    limit_list[4] = $urandom;
    limit_list[5] = $urandom_range(30, 200);
    for (int i = 0; i < 6; i++) begin
      set_max_body(limit_list[i]);
      target = bytes_sent + 80;
      while (bytes_sent < target) send_random_body();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_stall   <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    clear_parser();
    max_body = hcbd_pkg::MAX_BODY_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_chunk_basics();
    test_size_limits();
    test_random_streams();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hdl/hcbd_pkg.sv
hdl/hcbd_step.sv
hdl/http_chunked_body_decoder.sv
verif/testbench.sv
